@@ rtl/fms_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fms_pkg: shared types and codes for the flight mode sequencer
// Item and result beats, threshold registers, and mode/LED/action codes.
// ----------------------------------------------------------------------------
package fms_pkg;

	// Configuration port address width (four 32-bit registers)
	localparam int CFG_ADDR_W = 4;

	// Mode codes
	localparam logic [3:0] MODE_STARTUP   = 4'd0;
	localparam logic [3:0] MODE_GYRO      = 4'd1;
	localparam logic [3:0] MODE_ESC_START = 4'd2;
	localparam logic [3:0] MODE_LF        = 4'd3;
	localparam logic [3:0] MODE_RF        = 4'd4;
	localparam logic [3:0] MODE_RR        = 4'd5;
	localparam logic [3:0] MODE_LR        = 4'd6;
	localparam logic [3:0] MODE_STOP      = 4'd7;
	localparam logic [3:0] MODE_STARTING  = 4'd8;
	localparam logic [3:0] MODE_FLIGHT    = 4'd9;

	// LED commands
	localparam logic [2:0] LED_KEEP  = 3'd0;
	localparam logic [2:0] LED_OFF   = 3'd1;
	localparam logic [2:0] LED_ON    = 3'd2;
	localparam logic [2:0] LED_B250  = 3'd3;
	localparam logic [2:0] LED_B500  = 3'd4;
	localparam logic [2:0] LED_B1000 = 3'd5;

	// Requested actions
	localparam logic [2:0] ACT_NONE      = 3'd0;
	localparam logic [2:0] ACT_GYRO      = 3'd1;
	localparam logic [2:0] ACT_ESC_START = 3'd2;
	localparam logic [2:0] ACT_ESC_CHAN  = 3'd3;
	localparam logic [2:0] ACT_STOP      = 3'd4;
	localparam logic [2:0] ACT_RESET     = 3'd5;
	localparam logic [2:0] ACT_FLY       = 3'd6;

	// ESC channels
	localparam logic [1:0] CHAN_LF = 2'd0;
	localparam logic [1:0] CHAN_RF = 2'd1;
	localparam logic [1:0] CHAN_RR = 2'd2;
	localparam logic [1:0] CHAN_LR = 2'd3;

	// Threshold register reset values
	localparam logic [11:0] STICK_LOW_RST   = 12'd1012;
	localparam logic [11:0] CENTRE_LOW_RST  = 12'd1488;
	localparam logic [11:0] CENTRE_HIGH_RST = 12'd1512;
	localparam logic [11:0] STICK_HIGH_RST  = 12'd1988;

	typedef struct packed {
		logic        gyro_request_prev;
		logic        gyro_request_now;
		logic        esc_request_prev;
		logic        esc_request_now;
		logic        push_button;
		logic        gyro_cal_finished;
		logic        esc_cal_finished;
		logic [11:0] yaw_stick;
		logic [11:0] throttle_stick;
	} fms_item_t;

	typedef struct packed {
		logic [3:0] mode_now;
		logic [2:0] led_a_cmd;
		logic [2:0] led_b_cmd;
		logic [2:0] action;
		logic [1:0] esc_channel;
	} fms_result_t;

	typedef struct packed {
		logic [11:0] stick_low_limit;
		logic [11:0] centre_low_limit;
		logic [11:0] centre_high_limit;
		logic [11:0] stick_high_limit;
	} fms_cfg_t;

	typedef struct packed {
		logic [3:0] mode;
		logic       esc_done;
	} fms_state_t;

endpackage
`default_nettype wire

@@ rtl/fms_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fms_cfg_regs: stick threshold registers
// APB-style write/read of the four 12-bit stick limits.
// ----------------------------------------------------------------------------
module fms_cfg_regs
	import fms_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output fms_cfg_t                   cfg
);

	localparam logic [1:0] REG_STICK_LOW   = 2'd0;
	localparam logic [1:0] REG_CENTRE_LOW  = 2'd1;
	localparam logic [1:0] REG_CENTRE_HIGH = 2'd2;
	localparam logic [1:0] REG_STICK_HIGH  = 2'd3;

	fms_cfg_t   cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;
	logic [11:0] rd_val;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	// Register writes, access phase only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stick_low_limit   <= STICK_LOW_RST;
			cfg_q.centre_low_limit  <= CENTRE_LOW_RST;
			cfg_q.centre_high_limit <= CENTRE_HIGH_RST;
			cfg_q.stick_high_limit  <= STICK_HIGH_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_STICK_LOW:   cfg_q.stick_low_limit   <= pwdata[11:0];
				REG_CENTRE_LOW:  cfg_q.centre_low_limit  <= pwdata[11:0];
				REG_CENTRE_HIGH: cfg_q.centre_high_limit <= pwdata[11:0];
				REG_STICK_HIGH:  cfg_q.stick_high_limit  <= pwdata[11:0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (reg_idx)
			REG_STICK_LOW:   rd_val = cfg_q.stick_low_limit;
			REG_CENTRE_LOW:  rd_val = cfg_q.centre_low_limit;
			REG_CENTRE_HIGH: rd_val = cfg_q.centre_high_limit;
			REG_STICK_HIGH:  rd_val = cfg_q.stick_high_limit;
			default:         rd_val = 12'd0;
		endcase
	end

	assign prdata = {20'd0, rd_val};
	assign cfg    = cfg_q;

endmodule
`default_nettype wire

@@ rtl/fms_mode_logic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fms_mode_logic: next mode and tick outputs
// Combinational mode transition, LED commands, action and ESC channel.
// ----------------------------------------------------------------------------
module fms_mode_logic
	import fms_pkg::*;
(
	input  wire fms_state_t state,
	input  wire fms_item_t  item,
	input  wire fms_cfg_t   cfg,
	output fms_state_t      state_next,
	output fms_result_t     result
);

	logic raised;
	logic yaw_low;
	logic yaw_centred;
	logic yaw_high;
	logic gyro_fall;
	logic esc_fall;

	// Stick compares and switch edges
	assign raised      = item.throttle_stick >= cfg.stick_low_limit;
	assign yaw_low     = item.yaw_stick <= cfg.stick_low_limit;
	assign yaw_centred = (item.yaw_stick >= cfg.centre_low_limit) &&
	                     (item.yaw_stick <= cfg.centre_high_limit);
	assign yaw_high    = item.yaw_stick >= cfg.stick_high_limit;
	assign gyro_fall   = item.gyro_request_prev && !item.gyro_request_now;
	assign esc_fall    = item.esc_request_prev && !item.esc_request_now;

	always_comb begin
		state_next         = state;
		result.led_a_cmd   = LED_KEEP;
		result.led_b_cmd   = LED_KEEP;
		result.action      = ACT_NONE;
		result.esc_channel = CHAN_LF;

		unique case (state.mode)
			MODE_STARTUP: begin
				if (gyro_fall) begin
					state_next.mode  = MODE_GYRO;
					result.led_a_cmd = LED_OFF;
				end else begin
					result.led_a_cmd = LED_B500;
				end
			end
			MODE_GYRO: begin
				result.action = ACT_GYRO;
				if (item.gyro_cal_finished) begin
					state_next.mode  = MODE_STOP;
					result.led_b_cmd = LED_OFF;
				end else begin
					result.led_b_cmd = LED_B500;
				end
			end
			MODE_ESC_START: begin
				result.action = ACT_ESC_START;
				if (item.push_button) state_next.mode = MODE_LF;
			end
			MODE_LF: begin
				result.action      = ACT_ESC_CHAN;
				result.esc_channel = CHAN_LF;
				if (item.esc_cal_finished) begin
					state_next.mode  = MODE_RF;
					result.led_a_cmd = LED_ON;
				end
			end
			MODE_RF: begin
				result.action      = ACT_ESC_CHAN;
				result.esc_channel = CHAN_RF;
				if (item.esc_cal_finished) begin
					state_next.mode  = MODE_RR;
					result.led_a_cmd = LED_OFF;
					result.led_b_cmd = LED_ON;
				end
			end
			MODE_RR: begin
				result.action      = ACT_ESC_CHAN;
				result.esc_channel = CHAN_RR;
				if (item.esc_cal_finished) begin
					state_next.mode  = MODE_LR;
					result.led_a_cmd = LED_ON;
				end
			end
			MODE_LR: begin
				result.action      = ACT_ESC_CHAN;
				result.esc_channel = CHAN_LR;
				if (item.esc_cal_finished) begin
					state_next.mode     = MODE_STOP;
					state_next.esc_done = 1'b1;
				end
			end
			MODE_STOP: begin
				// ESC calibration is offered once per reset
				if (!state.esc_done && esc_fall) begin
					state_next.mode  = MODE_ESC_START;
					result.led_a_cmd = LED_OFF;
					result.led_b_cmd = LED_OFF;
				end else begin
					result.led_a_cmd = LED_B1000;
					result.led_b_cmd = LED_B1000;
					if (yaw_low && raised) state_next.mode = MODE_STARTING;
				end
			end
			MODE_STARTING: begin
				if (yaw_centred && raised) begin
					state_next.mode = MODE_FLIGHT;
					result.action   = ACT_RESET;
				end else begin
					result.led_a_cmd = LED_B500;
					result.led_b_cmd = LED_B500;
				end
			end
			MODE_FLIGHT: begin
				if (yaw_high && raised) begin
					state_next.mode = MODE_STOP;
					result.action   = ACT_STOP;
				end else begin
					result.led_a_cmd = LED_B250;
					result.led_b_cmd = LED_B250;
					result.action    = ACT_FLY;
				end
			end
			default: begin
				// unused codes hold and report nothing
			end
		endcase

		result.mode_now = state_next.mode;
	end

endmodule
`default_nettype wire

@@ rtl/flight_mode_sequencer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// flight_mode_sequencer: quadcopter flight mode sequencer
// Stages: a beat in the input register moves to the result register when that
// register is free (two register stages: input register, result register).
// Throughput: one beat per cycle while result_stall is low; the mode register
// updates as a beat moves from the input register to the result register.
// Reset: mode returns to startup, ESC-calibration-done clears, thresholds take
// their defaults, both stages empty. No clearing pass.
// ----------------------------------------------------------------------------
module flight_mode_sequencer
	import fms_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	// item channel
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire fms_item_t             item,
	// result channel
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output fms_result_t                result
);

	fms_cfg_t    cfg;
	fms_state_t  state_q;
	fms_state_t  state_next;
	fms_result_t step_result;
	fms_item_t   item_s1;
	logic        valid_s1;
	fms_result_t result_q;
	logic        result_valid_q;
	logic        advance;
	logic        accept;

	assign pready = 1'b1;

	fms_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	fms_mode_logic u_logic (
		.state      (state_q),
		.item       (item_s1),
		.cfg        (cfg),
		.state_next (state_next),
		.result     (step_result)
	);

	// Handshake: the input stage moves whenever the result register frees up
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_s1 <= item;
	end

	// Mode state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode     <= MODE_STARTUP;
			state_q.esc_done <= 1'b0;
			result_valid_q   <= 1'b0;
		end else if (advance) begin
			state_q        <= state_next;
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) result_q <= step_result;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// ESC calibration, once done, stays done until reset
	a_esc_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.esc_done |=> state_q.esc_done)
		else $error("esc calibration done flag cleared");

	// A loaded input stage with room downstream always yields a result beat
	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !(result_valid_q && result_stall)) |=> result_valid_q)
		else $error("input stage did not advance");

	// Channel only carries meaning during ESC channel calibration
	a_chan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.action != ACT_ESC_CHAN) |->
		(result_q.esc_channel == CHAN_LF))
		else $error("esc channel set outside channel calibration");

	// Reported mode always matches the state register after the beat
	a_mode_track: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (result_q.mode_now == state_q.mode))
		else $error("result mode differs from state");
`endif

endmodule
`default_nettype wire
